// ===== rtl/core/riff_movi_chunk_demux_top_defines.svh =====
// Assertion macros used by the checker file of the movi chunk demultiplexer.
// Depends on nothing; included by rmcd_checker.sv.
`ifndef RIFF_MOVI_CHUNK_DEMUX_TOP_DEFINES_SVH
`define RIFF_MOVI_CHUNK_DEMUX_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define RMCD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rmcd: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define RMCD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rmcd: next-cycle check failed");

`endif

// ===== rtl/core/rmcd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and digit helpers of the movi chunk demultiplexer.
// No dependencies; imported by rmcd_queue, rmcd_front, the top level and the bench.
package rmcd_pkg;

  localparam int RMCD_QDEPTH = 4;
  localparam int RMCD_QPTR_W = $clog2(RMCD_QDEPTH);
  localparam int RMCD_QCNT_W = $clog2(RMCD_QDEPTH + 1);

  localparam int RMCD_CFG_W = 7;

  // Register indexes of the configuration port.
  localparam logic RMCD_CFG_VIDEO_STREAM = 1'b0;
  localparam logic RMCD_CFG_AUDIO_STREAM = 1'b1;

  // Characters used in tag matching.
  localparam logic [31:0] RMCD_TAG_LIST = 32'h5453_494C; // "LIST", first char low
  localparam logic [7:0]  RMCD_CH_ZERO  = 8'h30;
  localparam logic [7:0]  RMCD_CH_D_LO  = 8'h64;
  localparam logic [7:0]  RMCD_CH_W_LO  = 8'h77;
  localparam logic [7:0]  RMCD_CH_B_LO  = 8'h62;
  localparam logic [7:0]  RMCD_CH_B_UP  = 8'h42;
  localparam logic [7:0]  RMCD_CH_C_LO  = 8'h63;
  localparam logic [7:0]  RMCD_CH_C_UP  = 8'h43;

  typedef enum logic [4:0] {
    PH_HEADER   = 5'b00001,
    PH_LISTTYPE = 5'b00010,
    PH_EMIT     = 5'b00100,
    PH_SKIP     = 5'b01000,
    PH_PAD      = 5'b10000
  } rmcd_phase_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       stream_kind;
    logic       chunk_first;
    logic       chunk_last;
  } rmcd_word_t;

  typedef struct packed {
    logic       valid;
    rmcd_word_t word;
  } rmcd_push_t;

  // Tens value of a 7-bit stream number: compare against each multiple of ten.
  function automatic logic [3:0] rmcd_tens(input logic [RMCD_CFG_W-1:0] n);
    logic [3:0] t;
    t = 4'd0;
    for (int k = 1; k <= 12; k++) begin
      if (n >= RMCD_CFG_W'(k * 10)) t = 4'(k);
    end
    return t;
  endfunction

  function automatic logic [7:0] rmcd_tens_char(input logic [RMCD_CFG_W-1:0] n);
    return RMCD_CH_ZERO + {4'd0, rmcd_tens(n)};
  endfunction

  function automatic logic [7:0] rmcd_ones_char(input logic [RMCD_CFG_W-1:0] n);
    logic [RMCD_CFG_W-1:0] ones;
    ones = n - RMCD_CFG_W'(rmcd_tens(n) * 10);
    return RMCD_CH_ZERO + {{(8 - RMCD_CFG_W){1'b0}}, ones};
  endfunction

endpackage

// ===== rtl/core/rmcd_queue.sv =====
`timescale 1ns / 1ps
// Result word queue between the parsing front and the result ports.
// Depends on rmcd_pkg.
module rmcd_queue
  import rmcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  rmcd_push_t wr,
  input  logic       pop,
  output logic       full,
  output logic       empty,
  output rmcd_word_t rd_word
);

  rmcd_word_t             mem [RMCD_QDEPTH];
  logic [RMCD_QPTR_W-1:0] wr_ptr;
  logic [RMCD_QPTR_W-1:0] rd_ptr;
  logic [RMCD_QCNT_W-1:0] count;
  logic                   do_push;
  logic                   do_pop;

  localparam logic [RMCD_QPTR_W-1:0] PTR_ONE = RMCD_QPTR_W'(1);
  localparam logic [RMCD_QCNT_W-1:0] CNT_ONE = RMCD_QCNT_W'(1);

  assign full    = (count == RMCD_QCNT_W'(RMCD_QDEPTH));
  assign empty   = (count == '0);
  assign do_push = wr.valid && !full;
  assign do_pop  = pop && !empty;
  assign rd_word = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= wr.word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + PTR_ONE;
      if (do_pop)  rd_ptr <= rd_ptr + PTR_ONE;
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_ONE;
        2'b01:   count <= count - CNT_ONE;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/core/rmcd_front.sv =====
`timescale 1ns / 1ps
// Byte parser: collects chunk headers, matches stream tags, marks payload words.
// Depends on rmcd_pkg; feeds rmcd_queue.
module rmcd_front
  import rmcd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [7:0]            in_byte,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_index,
  input  logic [RMCD_CFG_W-1:0] cfg_data,
  output rmcd_push_t            wr
);

  rmcd_phase_t phase, phase_next;
  logic [63:0] header_shift, header_shift_next;
  logic [2:0]  byte_count, byte_count_next;
  logic [31:0] remaining, remaining_next;
  logic        pad_pending, pad_pending_next;
  logic        current_kind, current_kind_next;
  logic        first_pending, first_pending_next;

  logic [7:0]  video_tens, video_ones, audio_tens, audio_ones;

  logic [63:0] shift_in;
  logic [31:0] tag, len;
  logic        is_list, is_video, is_audio;

  // Stream digits are formed at write time so header compare stays shallow.
  always_ff @(posedge clk) begin
    if (rst) begin
      video_tens <= rmcd_tens_char(RMCD_CFG_W'(0));
      video_ones <= rmcd_ones_char(RMCD_CFG_W'(0));
      audio_tens <= rmcd_tens_char(RMCD_CFG_W'(99));
      audio_ones <= rmcd_ones_char(RMCD_CFG_W'(99));
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        RMCD_CFG_VIDEO_STREAM: begin
          video_tens <= rmcd_tens_char(cfg_data);
          video_ones <= rmcd_ones_char(cfg_data);
        end
        RMCD_CFG_AUDIO_STREAM: begin
          audio_tens <= rmcd_tens_char(cfg_data);
          audio_ones <= rmcd_ones_char(cfg_data);
        end
      endcase
    end
  end

  assign shift_in = {in_byte, header_shift[63:8]};
  assign tag      = shift_in[31:0];
  assign len      = shift_in[63:32];
  assign is_list  = (tag == RMCD_TAG_LIST);
  assign is_video = (tag[7:0] == video_tens) && (tag[15:8] == video_ones) &&
                    (tag[23:16] == RMCD_CH_D_LO) &&
                    ((tag[31:24] == RMCD_CH_B_LO) || (tag[31:24] == RMCD_CH_B_UP) ||
                     (tag[31:24] == RMCD_CH_C_LO) || (tag[31:24] == RMCD_CH_C_UP));
  assign is_audio = (tag[7:0] == audio_tens) && (tag[15:8] == audio_ones) &&
                    (tag[23:16] == RMCD_CH_W_LO) && (tag[31:24] == RMCD_CH_B_LO);

  always_comb begin
    phase_next         = phase;
    header_shift_next  = header_shift;
    byte_count_next    = byte_count;
    remaining_next     = remaining;
    pad_pending_next   = pad_pending;
    current_kind_next  = current_kind;
    first_pending_next = first_pending;
    wr.valid             = 1'b0;
    wr.word.payload_byte = in_byte;
    wr.word.stream_kind  = current_kind;
    wr.word.chunk_first  = first_pending;
    wr.word.chunk_last   = (remaining == 32'd1);

    if (accept) begin
      unique case (phase)
        PH_LISTTYPE: begin
          // Drop the four list-type bytes, then descend into the list.
          if (byte_count >= 3'd3) begin
            byte_count_next = 3'd0;
            phase_next      = PH_HEADER;
          end else begin
            byte_count_next = byte_count + 3'd1;
          end
        end
        PH_EMIT: begin
          wr.valid           = 1'b1;
          first_pending_next = 1'b0;
          remaining_next     = remaining - 32'd1;
          if (remaining == 32'd1) begin
            phase_next      = pad_pending ? PH_PAD : PH_HEADER;
            byte_count_next = 3'd0;
          end
        end
        PH_SKIP: begin
          remaining_next = remaining - 32'd1;
          if (remaining == 32'd1) begin
            phase_next      = pad_pending ? PH_PAD : PH_HEADER;
            byte_count_next = 3'd0;
          end
        end
        PH_PAD: begin
          pad_pending_next = 1'b0;
          phase_next       = PH_HEADER;
          byte_count_next  = 3'd0;
        end
        default: begin
          phase_next        = PH_HEADER;
          header_shift_next = shift_in;
          if (byte_count == 3'd7) begin
            byte_count_next = 3'd0;
            if (is_list) begin
              phase_next = PH_LISTTYPE;
            end else begin
              pad_pending_next = len[0];
              remaining_next   = len;
              if (len == 32'd0) begin
                phase_next = PH_HEADER;
              end else if (is_video || is_audio) begin
                current_kind_next  = is_audio;
                first_pending_next = 1'b1;
                phase_next         = PH_EMIT;
              end else begin
                phase_next = PH_SKIP;
              end
            end
          end else begin
            byte_count_next = byte_count + 3'd1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    header_shift <= header_shift_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      byte_count    <= 3'd0;
      remaining     <= 32'd0;
      pad_pending   <= 1'b0;
      current_kind  <= 1'b0;
      first_pending <= 1'b0;
    end else begin
      phase         <= phase_next;
      byte_count    <= byte_count_next;
      remaining     <= remaining_next;
      pad_pending   <= pad_pending_next;
      current_kind  <= current_kind_next;
      first_pending <= first_pending_next;
    end
  end

endmodule

// ===== rtl/core/riff_movi_chunk_demux_top.sv =====
`timescale 1ns / 1ps
// AVI movi list demultiplexer: top level joining the parsing front and result queue.
// Depends on rmcd_pkg, rmcd_front and rmcd_queue.
//
// Usage:
//   Input channel: drive in_byte with the next raw byte of the movi list and
//   raise push; the byte is taken at a clock edge where push is high and full
//   is low. Result channel: while empty is low, the oldest payload word sits on
//   payload_byte, stream_kind, chunk_first and chunk_last; take it with pop.
//   Configuration: cfg_wr_en with cfg_index 0 sets the video stream number,
//   index 1 the audio stream number (7 bits each); write only while idle.
//   Flow: the front handles one byte per cycle in a single step, so the
//   sustained rate is one byte per clock while full is low. A payload byte is
//   written into the queue at the edge that takes it; the result ports show the queue head.
//   Header, list-type, skipped and pad bytes produce no word.
//   Stall: a four-word queue separates the sides. When the receiver holds pop
//   low, the queue fills and full rises, which holds the input side until a
//   word is popped; full depends only on queue occupancy.
//   Reset (rst, synchronous, active high): empty the queue, return the parser
//   to header collection, and load video stream 0 and audio stream 99.
module riff_movi_chunk_demux_top
  import rmcd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [7:0]            in_byte,
  output logic                  empty,
  input  logic                  pop,
  output logic [7:0]            payload_byte,
  output logic                  stream_kind,
  output logic                  chunk_first,
  output logic                  chunk_last,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_index,
  input  logic [RMCD_CFG_W-1:0] cfg_data
);

  rmcd_push_t wr;
  rmcd_word_t rd_word;
  logic       accept;

  // Take a byte whenever the queue has room, so a result always fits.
  assign accept = push && !full;

  rmcd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_byte   (in_byte),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .wr        (wr)
  );

  rmcd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .pop     (pop),
    .full    (full),
    .empty   (empty),
    .rd_word (rd_word)
  );

  assign payload_byte = rd_word.payload_byte;
  assign stream_kind  = rd_word.stream_kind;
  assign chunk_first  = rd_word.chunk_first;
  assign chunk_last   = rd_word.chunk_last;

endmodule

// ===== rtl/core/rmcd_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the movi chunk demultiplexer, bound to the top level.
// Depends on riff_movi_chunk_demux_top_defines.svh.
`include "riff_movi_chunk_demux_top_defines.svh"
module rmcd_checker (
  input logic       clk,
  input logic       rst,
  input logic       push,
  input logic       full,
  input logic       pop,
  input logic       empty,
  input logic [7:0] payload_byte,
  input logic       stream_kind,
  input logic       chunk_first,
  input logic       chunk_last
);

  // A full queue always holds a word.
  `RMCD_ASSERT_NOW(a_full_not_empty, clk, rst, full, !empty)

  // A pop with no byte taken frees a slot.
  `RMCD_ASSERT_NEXT(a_pop_frees, clk, rst, pop && !empty && !(push && !full), !full)

  // No word appears without a byte taken.
  `RMCD_ASSERT_NEXT(a_no_invented, clk, rst, empty && !(push && !full), empty)

  // Hold the waiting word while the receiver stalls.
  `RMCD_ASSERT_NEXT(a_word_holds, clk, rst, !empty && !pop,
    !empty && $stable(payload_byte) && $stable(stream_kind) &&
    $stable(chunk_first) && $stable(chunk_last))

endmodule

bind riff_movi_chunk_demux_top rmcd_checker u_rmcd_checker (
  .clk          (clk),
  .rst          (rst),
  .push         (push),
  .full         (full),
  .pop          (pop),
  .empty        (empty),
  .payload_byte (payload_byte),
  .stream_kind  (stream_kind),
  .chunk_first  (chunk_first),
  .chunk_last   (chunk_last)
);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the AVI movi chunk demultiplexer: a directed table, then random
// chunk streams, checked word by word against a byte-level parser model or typed words.
// Depends on rmcd_pkg and riff_movi_chunk_demux_top.
module tb;
  import rmcd_pkg::*;

  localparam int          CYCLE_LIMIT  = 1_000_000;
  localparam int          PHASE_BYTES  = 280;
  localparam int          RAND_PHASES  = 6;
  localparam int          LONG_HOLD    = 400;
  localparam logic [31:0] LIST_TAG     = "LIST";

  // How the words caused by one input byte are checked.
  typedef enum logic [1:0] {
    CHK_MODEL,  // whatever the parser model predicts
    CHK_NONE,   // the byte must cause no word
    CHK_TYPED   // the word typed into the directed table
  } check_e;

  typedef enum logic {
    ROW_STREAMS,  // write both stream numbers
    ROW_CHUNK     // send one chunk
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [6:0]  vid;
    logic [6:0]  aud;
    logic [31:0] tag;     // first character in the top byte
    logic [31:0] len;
    logic [7:0]  fill;    // payload byte i is fill + 29 * i
    check_e      chk;
    logic        exp_kind;
  } row_t;

  // Directed table. Rows checked by CHK_TYPED carry a one-byte payload, so the expected word
  // is simply {fill, exp_kind, first, last}.
  localparam int DIR_ROWS = 17;
  localparam row_t DIR_TABLE [DIR_ROWS] = '{
    // reset streams: video 0, audio 99
    '{ROW_CHUNK,   7'd0,   7'd0,   "00db", 32'd1,        8'hFF, CHK_TYPED, 1'b0},
    '{ROW_CHUNK,   7'd0,   7'd0,   "99wb", 32'd1,        8'h00, CHK_TYPED, 1'b1},
    '{ROW_CHUNK,   7'd0,   7'd0,   "00dB", 32'd3,        8'h80, CHK_MODEL, 1'b0},
    '{ROW_CHUNK,   7'd0,   7'd0,   "00dc", 32'd2,        8'h7F, CHK_MODEL, 1'b0},
    '{ROW_CHUNK,   7'd0,   7'd0,   "00dC", 32'd0,        8'h55, CHK_NONE,  1'b0},
    '{ROW_CHUNK,   7'd0,   7'd0,   "00Db", 32'd2,        8'h11, CHK_NONE,  1'b0},
    '{ROW_CHUNK,   7'd0,   7'd0,   "99Wb", 32'd1,        8'h22, CHK_NONE,  1'b0},
    '{ROW_CHUNK,   7'd0,   7'd0,   "LIST", 32'hFFFF_FFFF, 8'h72, CHK_NONE,  1'b0},
    '{ROW_CHUNK,   7'd0,   7'd0,   "99wB", 32'd1,        8'h33, CHK_NONE,  1'b0},
    // stream numbers at the extremes; 127 has a non-digit tens character
    '{ROW_STREAMS, 7'd127, 7'd0,   "----", 32'd0,        8'h00, CHK_NONE,  1'b0},
    '{ROW_CHUNK,   7'd0,   7'd0,   "<7dc", 32'd2,        8'hC3, CHK_MODEL, 1'b0},
    '{ROW_CHUNK,   7'd0,   7'd0,   "00wb", 32'd1,        8'h5A, CHK_TYPED, 1'b1},
    '{ROW_CHUNK,   7'd0,   7'd0,   "00db", 32'd1,        8'h44, CHK_NONE,  1'b0},
    '{ROW_STREAMS, 7'd99,  7'd127, "----", 32'd0,        8'h00, CHK_NONE,  1'b0},
    '{ROW_CHUNK,   7'd0,   7'd0,   "99dC", 32'd1,        8'hA5, CHK_TYPED, 1'b0},
    '{ROW_CHUNK,   7'd0,   7'd0,   "<7wb", 32'd3,        8'h01, CHK_MODEL, 1'b1},
    '{ROW_CHUNK,   7'd0,   7'd0,   "99wb", 32'd1,        8'h66, CHK_NONE,  1'b0}
  };

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  push;
  logic                  full;
  logic [7:0]            in_byte;
  logic                  empty;
  logic                  pop;
  logic [7:0]            payload_byte;
  logic                  stream_kind;
  logic                  chunk_first;
  logic                  chunk_last;
  logic                  cfg_wr_en;
  logic                  cfg_index;
  logic [RMCD_CFG_W-1:0] cfg_data;

  // Sideband that travels with each offered byte, read when the byte is taken.
  check_e     byte_chk;
  rmcd_word_t typed_word;

  riff_movi_chunk_demux_top DUT (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .in_byte      (in_byte),
    .empty        (empty),
    .pop          (pop),
    .payload_byte (payload_byte),
    .stream_kind  (stream_kind),
    .chunk_first  (chunk_first),
    .chunk_last   (chunk_last),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------------------
  // Parser model: its own copy of the stream numbers and parse state
  // ---------------------------------------------------------------------------------------
  logic [6:0]  vid_num;
  logic [6:0]  aud_num;
  rmcd_phase_t parse_ph;
  logic [63:0] hdr;        // newest byte enters at the top
  logic [2:0]  hcnt;       // bytes of header or list type seen
  logic [31:0] left;       // payload bytes still to emit or skip
  logic        odd_len;
  logic        cur_kind;
  logic        first_flag;

  rmcd_word_t  expected_words[$];
  int          errors;
  int          bytes_sent;
  int          hold_requests;
  bit          tx_quiet;
  bit          rx_quiet;

  function automatic logic [7:0] digit_hi(input logic [6:0] n);
    return RMCD_CH_ZERO + 8'(n / 7'd10);
  endfunction

  function automatic logic [7:0] digit_lo(input logic [6:0] n);
    return RMCD_CH_ZERO + 8'(n % 7'd10);
  endfunction

  task automatic reset_parser();
    vid_num    = 7'd0;
    aud_num    = 7'd99;
    parse_ph   = PH_HEADER;
    hdr        = '0;
    hcnt       = '0;
    left       = '0;
    odd_len    = 1'b0;
    cur_kind   = 1'b0;
    first_flag = 1'b0;
  endtask

  // Advance the parser by one byte; return 1 when the byte yields a payload word.
  function automatic bit parse_byte(input logic [7:0] b, output rmcd_word_t w);
    bit is_vid;
    bit is_aud;
    w = '0;
    case (parse_ph)
      PH_LISTTYPE: begin
        if (hcnt >= 3'd3) begin
          hcnt     = '0;
          parse_ph = PH_HEADER;
        end else begin
          hcnt = hcnt + 3'd1;
        end
      end
      PH_EMIT: begin
        w.payload_byte = b;
        w.stream_kind  = cur_kind;
        w.chunk_first  = first_flag;
        w.chunk_last   = (left == 32'd1);
        first_flag     = 1'b0;
        left           = left - 32'd1;
        if (left == '0) begin
          parse_ph = odd_len ? PH_PAD : PH_HEADER;
          hcnt     = '0;
        end
        return 1'b1;
      end
      PH_SKIP: begin
        left = left - 32'd1;
        if (left == '0) begin
          parse_ph = odd_len ? PH_PAD : PH_HEADER;
          hcnt     = '0;
        end
      end
      PH_PAD: begin
        odd_len  = 1'b0;
        parse_ph = PH_HEADER;
        hcnt     = '0;
      end
      default: begin
        parse_ph = PH_HEADER;
        hdr      = {b, hdr[63:8]};
        if (hcnt == 3'd7) begin
          hcnt = '0;
          if (hdr[31:0] == RMCD_TAG_LIST) begin
            parse_ph = PH_LISTTYPE;
          end else begin
            is_vid = hdr[7:0] == digit_hi(vid_num) && hdr[15:8] == digit_lo(vid_num) &&
                     hdr[23:16] == RMCD_CH_D_LO &&
                     (hdr[31:24] == RMCD_CH_B_LO || hdr[31:24] == RMCD_CH_B_UP ||
                      hdr[31:24] == RMCD_CH_C_LO || hdr[31:24] == RMCD_CH_C_UP);
            is_aud = hdr[7:0] == digit_hi(aud_num) && hdr[15:8] == digit_lo(aud_num) &&
                     hdr[23:16] == RMCD_CH_W_LO && hdr[31:24] == RMCD_CH_B_LO;
            odd_len = hdr[32];
            left    = hdr[63:32];
            if (left == '0) begin
              parse_ph = PH_HEADER;
            end else if (is_vid || is_aud) begin
              cur_kind   = is_aud;
              first_flag = 1'b1;
              parse_ph   = PH_EMIT;
            end else begin
              parse_ph = PH_SKIP;
            end
          end
        end else begin
          hcnt = hcnt + 3'd1;
        end
      end
    endcase
    return 1'b0;
  endfunction

  task automatic report(input string what, input int got, input int want);
    if (errors < 40) $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  // ---------------------------------------------------------------------------------------
  // Scoreboard: check popped words, track register writes, predict taken bytes
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    rmcd_word_t want;
    rmcd_word_t pred;
    bit         made;
    if (!rst) begin
      if (pop && !empty) begin
        if (expected_words.size() == 0) begin
          report("unexpected word", payload_byte, 0);
        end else begin
          want = expected_words.pop_front();
          if (payload_byte !== want.payload_byte)
            report("payload_byte", payload_byte, want.payload_byte);
          if (stream_kind !== want.stream_kind)
            report("stream_kind", stream_kind, want.stream_kind);
          if (chunk_first !== want.chunk_first)
            report("chunk_first", chunk_first, want.chunk_first);
          if (chunk_last !== want.chunk_last)
            report("chunk_last", chunk_last, want.chunk_last);
        end
      end
      if (cfg_wr_en) begin
        if (cfg_index == RMCD_CFG_VIDEO_STREAM) vid_num = cfg_data;
        else aud_num = cfg_data;
      end
      if (push && !full) begin
        // Always step the model so its state stays in line, even for typed rows.
        made = parse_byte(in_byte, pred);
        case (byte_chk)
          CHK_MODEL: if (made) expected_words.push_back(pred);
          CHK_TYPED: expected_words.push_back(typed_word);
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------------------
  function automatic int pick_gap(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Idle for a random gap, which may be empty, then offer the byte and hold it until the block takes it.
  task automatic send_byte(input logic [7:0] b, input check_e chk, input rmcd_word_t w);
    int n;
    n = pick_gap(tx_quiet);
    if (n > 0) begin
      push <= 1'b0;
      repeat (n) @(posedge clk);
    end
    push       <= 1'b1;
    in_byte    <= b;
    byte_chk   <= chk;
    typed_word <= w;
    @(posedge clk);
    while (full) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_chunk(input logic [31:0] tag, input logic [31:0] len,
                            input logic [7:0] fill, input bit rand_body,
                            input check_e chk, input logic kind);
    check_e     frame_chk;
    logic [7:0] b;
    rmcd_word_t w;
    // Header and pad bytes never make a word; typed rows only type the payload.
    frame_chk = (chk == CHK_MODEL) ? CHK_MODEL : CHK_NONE;
    w = '0;
    for (int i = 0; i < 4; i++) send_byte(tag[31 - 8 * i -: 8], frame_chk, w);
    for (int i = 0; i < 4; i++) send_byte(len[8 * i +: 8], frame_chk, w);
    if (tag == LIST_TAG) begin
      // list type, then descend: the list length is never used
      for (int i = 0; i < 4; i++) begin
        b = rand_body ? 8'($urandom) : fill + 8'(29 * i);
        send_byte(b, frame_chk, w);
      end
    end else begin
      for (int i = 0; i < int'(len); i++) begin
        b = rand_body ? 8'($urandom) : fill + 8'(29 * i);
        w.payload_byte = b;
        w.stream_kind  = kind;
        w.chunk_first  = (i == 0);
        w.chunk_last   = (i == int'(len) - 1);
        send_byte(b, chk, w);
      end
      w = '0;
      if (len[0]) send_byte(rand_body ? 8'($urandom) : fill, frame_chk, w);
    end
  endtask

  // Drop push, let every expected word drain, then write both stream numbers.
  task automatic set_streams(input logic [6:0] v, input logic [6:0] a);
    push <= 1'b0;
    // Step past the last accepting edge so its word is already queued.
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= RMCD_CFG_VIDEO_STREAM;
    cfg_data  <= v;
    @(posedge clk);
    cfg_index <= RMCD_CFG_AUDIO_STREAM;
    cfg_data  <= a;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // One well-framed chunk with random content; a share of tags are near misses or junk.
  task automatic rand_chunk(input logic [6:0] v, input logic [6:0] a);
    logic [31:0] tag;
    logic [31:0] len;
    logic [7:0]  last_ch;
    int          r;
    int          q;
    int          pos;
    r = $urandom_range(0, 99);
    q = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0: last_ch = RMCD_CH_B_LO;
      1: last_ch = RMCD_CH_B_UP;
      2: last_ch = RMCD_CH_C_LO;
      default: last_ch = RMCD_CH_C_UP;
    endcase
    if (q < 10) len = 32'd0;
    else if (q < 80) len = 32'($urandom_range(1, 8));
    else if (q < 97) len = 32'($urandom_range(9, 40));
    else len = 32'($urandom_range(41, 200));
    if (r < 40) begin
      tag = {digit_hi(v), digit_lo(v), RMCD_CH_D_LO, last_ch};
    end else if (r < 65) begin
      tag = {digit_hi(a), digit_lo(a), RMCD_CH_W_LO, RMCD_CH_B_LO};
    end else if (r < 73) begin
      tag = LIST_TAG;
      len = $urandom;
    end else if (r < 90) begin
      // near miss: corrupt one character of a matching tag
      tag = (r & 1) ? {digit_hi(v), digit_lo(v), RMCD_CH_D_LO, last_ch}
                    : {digit_hi(a), digit_lo(a), RMCD_CH_W_LO, RMCD_CH_B_LO};
      pos = $urandom_range(0, 3);
      tag[8 * pos +: 8] = 8'($urandom);
    end else begin
      tag = $urandom;
    end
    send_chunk(tag, len, 8'h00, 1'b1, CHK_MODEL, 1'b0);
  endtask

  // ---------------------------------------------------------------------------------------
  // Receiver side: random pop runs and gaps, plus one long hold on request
  // ---------------------------------------------------------------------------------------
  initial begin : receiver
    int n;
    int holds_done;
    holds_done = 0;
    pop <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (holds_done != hold_requests) begin
        // Hold off long enough for the queue to fill and push back on the sender.
        holds_done++;
        pop <= 1'b0;
        for (int c = 0; c < LONG_HOLD; c++) @(posedge clk);
      end else begin
        n = $urandom_range(1, 24);
        pop <= 1'b1;
        repeat (n) @(posedge clk);
        n = pick_gap(rx_quiet);
        if (n > 0) begin
          pop <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
    end
  end

  // Watchdog: end the run with an error once the cycle limit is reached.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------------------
  // Main stimulus
  // ---------------------------------------------------------------------------------------
  initial begin : stimulus
    logic [6:0] v;
    logic [6:0] a;
    int         start;
    errors        = 0;
    bytes_sent    = 0;
    hold_requests = 0;
    tx_quiet      = 1'b0;
    rx_quiet      = 1'b0;
    reset_parser();
    rst        <= 1'b1;
    push       <= 1'b0;
    in_byte    <= '0;
    byte_chk   <= CHK_NONE;
    typed_word <= '0;
    cfg_wr_en  <= 1'b0;
    cfg_index  <= RMCD_CFG_VIDEO_STREAM;
    cfg_data   <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table, starting from the reset stream numbers.
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIR_TABLE[i].kind == ROW_STREAMS)
        set_streams(DIR_TABLE[i].vid, DIR_TABLE[i].aud);
      else
        send_chunk(DIR_TABLE[i].tag, DIR_TABLE[i].len, DIR_TABLE[i].fill, 1'b0,
                   DIR_TABLE[i].chk, DIR_TABLE[i].exp_kind);
    end

    // Random phases: extremes of the stream numbers first, then random ones.
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: begin v = 7'd0;   a = 7'd99;  end
        1: begin v = 7'd127; a = 7'd0;   end
        2: begin v = 7'd99;  a = 7'd127; end
        default: begin
          v = 7'($urandom_range(0, 127));
          a = 7'($urandom_range(0, 127));
        end
      endcase
      set_streams(v, a);
      // Phase 1 fills the queue under a long receiver hold; phase 3 runs with no idling.
      if (p == 1) hold_requests++;
      tx_quiet = (p == 3);
      rx_quiet = (p == 3);
      start = bytes_sent;
      while (bytes_sent - start < PHASE_BYTES) rand_chunk(v, a);
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;

    // Unframed junk at the very end: it may lose sync, which the model follows.
    for (int i = 0; i < 40; i++) send_byte(8'($urandom), CHK_MODEL, '0);

    push <= 1'b0;
    // Step past the last accepting edge so its word is already queued.
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/rmcd_pkg.sv
rtl/core/rmcd_queue.sv
rtl/core/rmcd_front.sv
rtl/core/riff_movi_chunk_demux_top.sv
rtl/core/rmcd_checker.sv
verif/tb.sv
